// ===== hw/rtl/matrix_vector_multiply_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define MVMU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MVMU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mvmu_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit package
// Sizes, field widths, register indexes and pipeline tag type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvmu_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 1024;

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // configuration register widths and reset values
    localparam int COLS_CFG_W = 9;
    localparam int ROWS_CFG_W = 11;
    localparam int CFG_DATA_W = (COLS_CFG_W > ROWS_CFG_W) ? COLS_CFG_W : ROWS_CFG_W;
    localparam int CFG_IDX_W  = 1;
    localparam int COLS_RESET = 256;
    localparam int ROWS_RESET = 1024;

    // widths for "position + 1 >= count" compares
    localparam int COLS_CMP_W = (COLS_CFG_W > COL_W + 1) ? COLS_CFG_W : COL_W + 1;
    localparam int ROWS_CMP_W = (ROWS_CFG_W > ROW_W + 1) ? ROWS_CFG_W : ROW_W + 1;

    localparam int VAL_W = 32;
    localparam int SUM_W = 64;
    localparam int FRAC_W = 16;

    localparam int IN_TDATA_W  = ((2 * VAL_W + 7) / 8) * 8;
    localparam int OUT_ROW_W   = 10;
    localparam int OUT_TDATA_W = ((OUT_ROW_W + SUM_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS_IN_USE = 1'b0,
        CFG_ROWS_IN_USE = 1'b1
    } mvmu_cfg_idx_t;

    // control carried alongside a matrix beat through the pipeline
    typedef struct packed {
        logic             first;
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row;
    } mvmu_tag_t;

endpackage

// ===== hw/rtl/mvmu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port, one read port with registered data held between reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvmu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/matrix_vector_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit
// Row-major dense matrix times stored vector, Q16.16 in, saturated Q32.32 out.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_        in    s_tvalid/s_tready    tuser = cmd, tdata = value, bias
//  m_        out   m_tvalid/m_tready    tdata = row_index, row_sum; tlast = last
//  cfg_      in    cfg_wr_en            cfg_addr selects cols/rows in use
//
//  One beat per cycle sustained while s_tready is high. A row result is
//  registered after its last column: vector RAM read, multiplier register, accumulator.
//  Reset is synchronous; counters, valids and the accumulator clear, no RAM clear.
//  With the result register full, beats keep flowing until a second row end
//  reaches the accumulator; then s_tready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_vector_multiply_unit
    import mvmu_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] value, [63:32] bias
    input  logic                   s_tuser,   // [0] cmd
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] row_index, [73:10] row_sum
    output logic                   m_tlast
);

    // configuration
    logic [COLS_CFG_W-1:0] cols_cfg_reg;
    logic [ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [COLS_CMP_W-1:0] cols_eff;
    logic [ROWS_CMP_W-1:0] rows_eff;

    // counters
    logic [COL_W-1:0] load_ptr_reg, load_ptr_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             ptr_at_end, col_at_end, row_at_end;

    // handshake
    logic in_beat, mat_beat, vec_beat;
    logic out_free, s2_take, s2_free, s1_free;

    // stage 1: beat registered, vector element read
    logic                    s1_valid_reg;
    logic signed [VAL_W-1:0] s1_value_reg;
    logic signed [VAL_W-1:0] s1_bias_reg;
    mvmu_tag_t               s1_tag_reg;
    mvmu_tag_t               in_tag;
    logic [VAL_W-1:0]        vec_rd_data;
    logic signed [SUM_W-1:0] product;

    // stage 2: product registered
    logic                    s2_valid_reg;
    logic signed [SUM_W-1:0] s2_prod_reg;
    logic signed [VAL_W-1:0] s2_bias_reg;
    mvmu_tag_t               s2_tag_reg;

    // accumulate and result
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic signed [SUM_W-1:0] acc_base, bias_wide;
    logic signed [SUM_W:0]   sum_wide;
    logic                    m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]        out_sum_reg;
    logic [OUT_ROW_W-1:0]    out_row_reg;
    logic                    out_last_reg;

    // ------------------------------------------------------------------
    // Register counts: 0 acts as 1, above the maximum acts as the maximum
    // ------------------------------------------------------------------
    always_comb begin
        if (cols_cfg_reg == '0) begin
            cols_eff = COLS_CMP_W'(1);
        end else if (COLS_CMP_W'(cols_cfg_reg) > COLS_CMP_W'(MAX_COLS)) begin
            cols_eff = COLS_CMP_W'(MAX_COLS);
        end else begin
            cols_eff = COLS_CMP_W'(cols_cfg_reg);
        end
        if (rows_cfg_reg == '0) begin
            rows_eff = ROWS_CMP_W'(1);
        end else if (ROWS_CMP_W'(rows_cfg_reg) > ROWS_CMP_W'(MAX_ROWS)) begin
            rows_eff = ROWS_CMP_W'(MAX_ROWS);
        end else begin
            rows_eff = ROWS_CMP_W'(rows_cfg_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= COLS_CFG_W'(COLS_RESET);
            rows_cfg_reg <= ROWS_CFG_W'(ROWS_RESET);
        end else if (cfg_wr_en) begin
            case (mvmu_cfg_idx_t'(cfg_addr))
                CFG_COLS_IN_USE: cols_cfg_reg <= cfg_wdata[COLS_CFG_W-1:0];
                CFG_ROWS_IN_USE: rows_cfg_reg <= cfg_wdata[ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: each stage moves when it is empty or the next one takes
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_tready;
    assign s2_take  = s2_valid_reg && (!s2_tag_reg.emit || out_free);
    assign s2_free  = !s2_valid_reg || s2_take;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_tready = s1_free;

    assign in_beat  = s_tvalid && s_tready;
    assign mat_beat = in_beat && s_tuser;
    assign vec_beat = in_beat && !s_tuser;

    // ------------------------------------------------------------------
    // Counters
    // ------------------------------------------------------------------
    assign ptr_at_end = (COLS_CMP_W'(load_ptr_reg) + COLS_CMP_W'(1)) >= cols_eff;
    assign col_at_end = (COLS_CMP_W'(col_reg) + COLS_CMP_W'(1)) >= cols_eff;
    assign row_at_end = (ROWS_CMP_W'(row_reg) + ROWS_CMP_W'(1)) >= rows_eff;

    always_comb begin
        load_ptr_next = load_ptr_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (vec_beat) begin
            load_ptr_next = ptr_at_end ? '0 : load_ptr_reg + 1'b1;
        end
        if (mat_beat) begin
            col_next = col_at_end ? '0 : col_reg + 1'b1;
            if (col_at_end) begin
                row_next = row_at_end ? '0 : row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_ptr_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end else begin
            load_ptr_reg <= load_ptr_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Vector store: written by vector beats, read at the column of a matrix beat
    // ------------------------------------------------------------------
    mvmu_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_COLS)
    ) u_vec_ram (
        .clk     (aclk),
        .wr_en   (vec_beat),
        .wr_addr (load_ptr_reg),
        .wr_data (s_tdata[VAL_W-1:0]),
        .rd_en   (mat_beat),
        .rd_addr (col_reg),
        .rd_data (vec_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------
    always_comb begin
        in_tag.first = (col_reg == '0);
        in_tag.emit  = col_at_end;
        in_tag.last  = row_at_end;
        in_tag.row   = row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= mat_beat;
        end
        if (mat_beat) begin
            s1_value_reg <= s_tdata[VAL_W-1:0];
            s1_bias_reg  <= s_tdata[2*VAL_W-1:VAL_W];
            s1_tag_reg   <= in_tag;
        end
    end

    // Q16.16 x Q16.16 is exact Q32.32
    assign product = SUM_W'(s1_value_reg) * SUM_W'($signed(vec_rd_data));

    // ------------------------------------------------------------------
    // Stage 2
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_free) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_free && s1_valid_reg) begin
            s2_prod_reg <= product;
            s2_bias_reg <= s1_bias_reg;
            s2_tag_reg  <= s1_tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Saturating accumulate; the row restarts from bias at column zero
    // ------------------------------------------------------------------
    assign bias_wide = {{(SUM_W-VAL_W-FRAC_W){s2_bias_reg[VAL_W-1]}}, s2_bias_reg,
                        {FRAC_W{1'b0}}};
    assign acc_base  = s2_tag_reg.first ? bias_wide : acc_reg;
    assign sum_wide  = {acc_base[SUM_W-1], acc_base} + {s2_prod_reg[SUM_W-1], s2_prod_reg};

    always_comb begin
        acc_next = acc_reg;
        if (s2_take) begin
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
                // clamp towards the sign of the true sum
                acc_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                acc_next = sum_wide[SUM_W-1:0];
            end
        end
        m_valid_next = m_valid_reg;
        if (s2_take && s2_tag_reg.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
        if (s2_take && s2_tag_reg.emit) begin
            out_sum_reg  <= acc_next;
            out_row_reg  <= OUT_ROW_W'(s2_tag_reg.row);
            out_last_reg <= s2_tag_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_sum_reg, out_row_reg});
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/mvmu_checker.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix_vector_multiply_unit_defines.svh"

module mvmu_checker
    import mvmu_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_wr_en,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] row_index, [73:10] row_sum
    input logic                   m_tlast
);

    // row index the next result beat must carry
    logic [OUT_ROW_W-1:0] exp_row_reg, exp_row_next;
    logic                 out_beat;
    logic                 in_beat;
    logic                 cfg_seen;

    assign out_beat = m_tvalid && m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign cfg_seen = cfg_wr_en;

    always_comb begin
        exp_row_next = exp_row_reg;
        if (out_beat) begin
            exp_row_next = m_tlast ? '0 : exp_row_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_row_reg <= '0;
        end else begin
            exp_row_reg <= exp_row_next;
        end
    end

    `MVMU_ASSERT_NEXT(a_reset_clears_out, aclk, 1'b1, !aresetn, !m_tvalid,
        "result valid after reset")
    `MVMU_ASSERT_NEXT(a_out_held, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed")
    `MVMU_ASSERT_SAME(a_row_order, aclk, aresetn, m_tvalid,
        m_tdata[OUT_ROW_W-1:0] == exp_row_reg, "row index out of sequence")
    `MVMU_ASSERT_NEXT(a_no_out_from_cfg, aclk, aresetn, !m_tvalid && !in_beat && cfg_seen,
        !m_tvalid, "result beat without input beat")

endmodule

bind matrix_vector_multiply_unit mvmu_checker u_mvmu_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-vector multiply unit testbench
// Streams vector loads and row-major matrix beats into the unit and checks
// every row result against a local predictor: Q16.16 products summed with
// saturation into Q32.32, row index and final-row flag. Sizes are reprogrammed
// between phases, mid-row included, and both stream sides stall at random.
// ----------------------------------------------------------------------------

module tb_top;
    import mvmu_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_PHASES   = 9;
    localparam int BIG_COLS     = 64;

    typedef struct packed {
        logic             cmd;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] bias;
    } mvm_beat_t;

    typedef struct packed {
        logic [OUT_ROW_W-1:0]    row_index;
        logic signed [SUM_W-1:0] row_sum;
        logic                    last;
    } row_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // predictor state
    logic [VAL_W-1:0]        vec_mem [MAX_COLS];
    int unsigned             vec_ptr  = 0;
    int unsigned             col_pos  = 0;
    int unsigned             row_pos  = 0;
    logic signed [SUM_W-1:0] acc      = '0;
    logic [COLS_CFG_W-1:0]   cols_reg = COLS_CFG_W'(COLS_RESET);
    logic [ROWS_CFG_W-1:0]   rows_reg = ROWS_CFG_W'(ROWS_RESET);

    // stimulus planning: which vector entries hold data, where the counters stand
    bit          plan_written [MAX_COLS];
    int unsigned plan_ptr  = 0;
    int unsigned plan_col  = 0;
    int unsigned plan_cols = COLS_RESET;
    int unsigned beats_queued = 0;

    mvm_beat_t   beats_to_send [$];
    row_result_t rows_due [$];
    mvm_beat_t   beat_on_bus;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches    = 0;
    int          cycle_count   = 0;

    matrix_vector_multiply_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned used_count(input int unsigned v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return s[SUM_W-1:0];
    endfunction

    // one accepted beat; returns 1 when it closes a row
    function automatic bit accumulate_beat(input mvm_beat_t b, output row_result_t res);
        int unsigned             ncols;
        int unsigned             nrows;
        logic signed [SUM_W-1:0] prod;
        ncols = used_count(cols_reg, MAX_COLS);
        nrows = used_count(rows_reg, MAX_ROWS);
        res   = '0;
        if (b.cmd == 1'b0) begin
            vec_mem[vec_ptr] = b.value;
            vec_ptr = (vec_ptr + 1 >= ncols) ? 0 : vec_ptr + 1;
            return 1'b0;
        end
        if (col_pos == 0)
            acc = longint'($signed(b.bias)) * 64'sd65536;
        prod = longint'($signed(b.value)) * longint'($signed(vec_mem[col_pos]));
        acc  = sat_add(acc, prod);
        if (col_pos + 1 >= ncols) begin
            res.row_index = OUT_ROW_W'(row_pos);
            res.row_sum   = acc;
            res.last      = (row_pos + 1 >= nrows);
            col_pos = 0;
            row_pos = res.last ? 0 : row_pos + 1;
            return 1'b1;
        end
        col_pos++;
        return 1'b0;
    endfunction

    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic void queue_load(input logic [VAL_W-1:0] value,
                                       input logic [VAL_W-1:0] bias);
        beats_to_send.push_back('{1'b0, value, bias});
        beats_queued++;
        if (plan_ptr < MAX_COLS)
            plan_written[plan_ptr] = 1'b1;
        plan_ptr = (plan_ptr + 1 >= plan_cols) ? 0 : plan_ptr + 1;
    endfunction

    function automatic void queue_matrix(input logic [VAL_W-1:0] value,
                                         input logic [VAL_W-1:0] bias);
        // top up the vector until the entry this column reads holds data
        while (!plan_written[plan_col])
            queue_load(pick_word(), $urandom());
        beats_to_send.push_back('{1'b1, value, bias});
        beats_queued++;
        plan_col = (plan_col + 1 >= plan_cols) ? 0 : plan_col + 1;
    endfunction

    function automatic void phase_plan(input int p, output int unsigned cols,
                                       output int unsigned rows, output int unsigned budget);
        case (p)
            0: begin cols = 0;   rows = 5;    budget = 80;  end
            1: begin cols = 3;   rows = 2047; budget = 100; end
            2: begin cols = 6;   rows = 0;    budget = 80;  end
            3: begin cols = 256; rows = 2;    budget = 1;   end
            4: begin cols = 2;   rows = 7;    budget = 100; end
            5: begin cols = 5;   rows = 1024; budget = 100; end
            6: begin cols = 1;   rows = 3;    budget = 80;  end
            7: begin cols = 511; rows = 1;    budget = 1;   end
            default: begin cols = 8; rows = 4; budget = 120; end
        endcase
    endfunction

    task automatic wait_idle();
        @(negedge aclk);
        while (beats_to_send.size() != 0 || s_tvalid || rows_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_sizes(input int unsigned cols, input int unsigned rows);
        int unsigned ncols;
        ncols = used_count(cols & 'h1FF, MAX_COLS);
        // a column left beyond the new last one still reads its own entry
        if (plan_col >= ncols && !plan_written[plan_col]) begin
            cols  = plan_col + 1;
            ncols = cols;
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_COLS_IN_USE;
        cfg_wdata <= CFG_DATA_W'(cols);
        @(posedge aclk);
        cfg_addr  <= CFG_ROWS_IN_USE;
        cfg_wdata <= CFG_DATA_W'(rows);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cols_reg  = COLS_CFG_W'(cols);
        rows_reg  = ROWS_CFG_W'(rows);
        plan_cols = ncols;
    endtask

    // driver
    always @(posedge aclk) begin
        row_result_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (accumulate_beat(beat_on_bus, res))
                    rows_due.push_back(res);
            end
            if (!s_tvalid || s_tready) begin
                if (beats_to_send.size() != 0 &&
                    int'($urandom_range(0, 99)) >= send_idle_pct) begin
                    beat_on_bus = beats_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {beat_on_bus.bias, beat_on_bus.value};
                    s_tuser  <= beat_on_bus.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        row_result_t want;
        row_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.row_index = m_tdata[OUT_ROW_W-1:0];
                got.row_sum   = m_tdata[OUT_ROW_W +: SUM_W];
                got.last      = m_tlast;
                if (rows_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected row result: index %0d sum %h last %b",
                                 got.row_index, got.row_sum, got.last);
                    mismatches++;
                end else begin
                    want = rows_due.pop_front();
                    if (got.row_index != want.row_index || got.row_sum != want.row_sum ||
                        got.last != want.last) begin
                        if (mismatches < 10)
                            $display({"row result: expected index %0d sum %h last %b, ",
                                      "got index %0d sum %h last %b"},
                                     want.row_index, want.row_sum, want.last,
                                     got.row_index, got.row_sum, got.last);
                        mismatches++;
                    end
                end
            end
            m_tready <= int'($urandom_range(0, 99)) >= recv_idle_pct;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned cols;
        int unsigned rows;
        int unsigned budget;
        int unsigned phase_start;
        int unsigned kind;
        send_idle_pct = 29;
        recv_idle_pct = 61;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        set_sizes(4, 3);
        // vector of extremes, then rows that clip high, clip low and close the matrix
        queue_load(32'h8000_0000, $urandom());
        queue_load(32'h8000_0000, $urandom());
        queue_load(32'h8000_0000, $urandom());
        queue_load(32'h0001_0000, $urandom());
        queue_matrix(32'h8000_0000, 32'h7FFF_FFFF);
        queue_matrix(32'h8000_0000, $urandom());
        queue_matrix(32'h8000_0000, $urandom());
        queue_matrix(32'hFFFF_FFFF, $urandom());
        queue_matrix(32'h7FFF_FFFF, 32'h8000_0000);
        queue_matrix(32'h7FFF_FFFF, $urandom());
        queue_matrix(32'h7FFF_FFFF, $urandom());
        queue_matrix(32'h0000_0000, $urandom());
        queue_matrix(32'h0001_0000, 32'hFFFF_0000);
        queue_load(32'h7FFF_FFFF, $urandom());  // overwrites entry 0 mid-row
        queue_matrix(32'h1234_5678, $urandom());
        queue_matrix(32'hFFFF_FFFF, $urandom());
        queue_matrix(32'h7FFF_FFFF, $urandom());
        // leave a row open, then shrink the column count under it
        queue_matrix(32'h0003_0000, 32'h0000_0001);
        queue_matrix(32'hFFFE_0000, $urandom());
        queue_matrix(32'h0000_8000, $urandom());
        set_sizes(2, 1);
        queue_matrix(32'h0001_0000, $urandom());
        queue_matrix(pick_word(), pick_word());
        queue_matrix(pick_word(), pick_word());

        for (int p = 0; p < NUM_PHASES; p++) begin
            phase_plan(p, cols, rows, budget);
            set_sizes(cols, rows);
            case (p / 3)
                0: begin send_idle_pct = 29; recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_start = beats_queued;
            while (beats_queued - phase_start < budget) begin
                kind = $urandom_range(0, 99);
                if (plan_cols > BIG_COLS || kind < 75) begin
                    // finish the current row with random content
                    do begin
                        if ($urandom_range(0, 9) == 0)
                            queue_load(pick_word(), $urandom());
                        queue_matrix(pick_word(), pick_word());
                    end while (plan_col != 0);
                end else if (kind < 88) begin
                    repeat (plan_cols) queue_load(pick_word(), $urandom());
                end else if ($urandom_range(0, 1) == 0) begin
                    queue_load(pick_word(), $urandom());
                end else begin
                    queue_matrix(pick_word(), pick_word());
                end
            end
        end

        wait_idle();
        repeat (2 * DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mvmu_pkg.sv
hw/rtl/mvmu_ram.sv
hw/rtl/matrix_vector_multiply_unit.sv
hw/rtl/mvmu_checker.sv
test/tb_top.sv
